// ----- rtl/core/edf_pkg.sv -----
package edf_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TW          = 32;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SPEED_W     = 8;
   localparam int ST_W        = 3;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_MISS    = 3'd1;
   localparam logic [ST_W-1:0] ST_OVERRUN = 3'd2;
   localparam logic [ST_W-1:0] ST_HORIZON = 3'd3;
   localparam logic [ST_W-1:0] ST_FULL    = 3'd4;
   localparam logic [ST_W-1:0] ST_HALTED  = 3'd5;

   localparam logic [1:0] CSR_SPEED  = 2'd0;
   localparam logic [1:0] CSR_OBREAK = 2'd1;
   localparam logic [1:0] CSR_BREAK  = 2'd2;

   typedef struct packed {
      logic [TW-1:0] deadline;
      logic [TW-1:0] overrun;
      logic [TW-1:0] remaining;
   } job_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INS,
      CELL_POP,
      CELL_HEAD
   } cell_op_type;

   typedef struct packed {
      cell_op_type   op;
      logic [TW-1:0] head_rem;
   } cell_ctl_type;

endpackage

// ----- rtl/core/edf_ifs.sv -----
interface edf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] arrival_time;
   logic [31:0] overrun_time;
   logic [31:0] abs_deadline;
   logic [31:0] work_amount;

   modport source (output valid, arrival_time, overrun_time, abs_deadline, work_amount,
                   input ready);
   modport sink (input valid, arrival_time, overrun_time, abs_deadline, work_amount,
                 output ready);
endinterface

interface edf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] time_now;
   logic [31:0] finished_count;
   logic [31:0] event_count;

   modport source (output valid, status, time_now, finished_count, event_count,
                   input ready);
   modport sink (input valid, status, time_now, finished_count, event_count,
                 output ready);
endinterface

// ----- rtl/core/edf_cell.sv -----
module edf_cell (
   input  logic                  clock,
   input  edf_pkg::cell_ctl_type ctl,
   input  logic                  head_sel,
   input  logic                  valid_i,
   input  edf_pkg::job_type      new_job,
   input  edf_pkg::job_type      prev_job,
   input  logic                  prev_ge,
   input  edf_pkg::job_type      next_job,
   output edf_pkg::job_type      job_o,
   output logic                  ge_o
);
   import edf_pkg::*;

   job_type job_ff;

   // ge: this entry stays ahead of the new job (FIFO among equal deadlines)
   assign ge_o  = valid_i && (job_ff.deadline <= new_job.deadline);
   assign job_o = job_ff;

   always_ff @(posedge clock) begin
      case (ctl.op)
         CELL_INS: begin
            if (!ge_o) job_ff <= prev_ge ? new_job : prev_job;
         end
         CELL_POP:  job_ff <= next_job;
         CELL_HEAD: begin
            if (head_sel) job_ff.remaining <= ctl.head_rem;
         end
         default: ;
      endcase
   end
endmodule

// ----- rtl/core/edf_div.sv -----
module edf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [edf_pkg::TW-1:0]        dividend,
   input  logic [edf_pkg::SPEED_W-1:0]   divisor,
   output logic                          done,
   output logic [edf_pkg::TW-1:0]        quo,
   output logic [edf_pkg::SPEED_W-1:0]   rem
);
   import edf_pkg::*;

   localparam int CNT_W = $clog2(TW + 1);

   logic [TW-1:0]      quo_ff, quo_in;
   logic [SPEED_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SPEED_W:0]   trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[TW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(TW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = SPEED_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[TW-2:0], 1'b1};
         end else begin
            rem_in = trial[SPEED_W-1:0];
            quo_in = {quo_ff[TW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule

// ----- rtl/core/edf_schedule_simulator_step.sv -----
// Preemptive EDF scheduling simulator, one job arrival per item.
// req: one job arrival (arrival, overrun time, deadline, work), in start order.
// rsp: one result item per request: status, time after the step, finished
//   jobs and event count (both saturating).
// csr: write-only; index 0 speed, 1 overrun break, 2 horizon. Write only
//   while idle.
// The job queue is a row of 16 cells kept sorted by deadline; a pop moves
// every cell at once, an insert the cells behind it; head is the running job.
// From acceptance, an item that serves no queued job passes S_EVAL, S_LOOP,
// S_FINAL and S_OUT (S_EVAL goes straight to S_OUT when halted, for the
// first job, or when the horizon has already passed). Each queued job served
// (completed or preempted) adds S_LOOP, S_DIV, S_MUL and S_APPLY; S_DIV waits
// on the bit-serial divider that splits remaining work by speed. Speed 0 skips
// the divider. One item in flight at a time; at the earliest, the next item is
// taken in the cycle after the result register loads.
// A finished result sits in an output register; the block accepts the next
// item while it waits. If rsp stalls, a second result waits in S_OUT until
// the register drains.
// Reset (synchronous, active high): time, queue fill, counters and flags
// clear; speed 1, overrun break off, horizon all ones.
module edf_schedule_simulator_step (
   input  logic            clock,
   input  logic            reset,
   edf_req_if.sink         req,
   edf_rsp_if.source       rsp,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_wdata
);
   import edf_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_EVAL  = 8'b0000_0010,
      S_LOOP  = 8'b0000_0100,
      S_DIV   = 8'b0000_1000,
      S_MUL   = 8'b0001_0000,
      S_APPLY = 8'b0010_0000,
      S_FINAL = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   state_type state_ff, state_in;

   // configuration
   logic [SPEED_W-1:0] speed_ff;
   logic               obreak_ff;
   logic [TW-1:0]      break_ff;

   // architectural state
   logic [TW-1:0]     sim_ff, sim_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [TW-1:0]     fin_ff, fin_in;
   logic [TW-1:0]     ev_ff, ev_in;
   logic              started_ff, started_in;
   logic              halted_ff, halted_in;

   // per-item working registers
   job_type           new_ff;
   logic [TW-1:0]     arr_ff, arr_in;
   logic [TW-1:0]     run_ff, run_in;
   logic [TW-1:0]     ovt_ff, ovt_in;
   logic              ovtv_ff, ovtv_in;
   logic [TW+SPEED_W-1:0] prod_ff;
   logic              part_ff;
   logic [ST_W-1:0]   st_ff, st_in;

   // result register
   logic              rv_ff;
   logic [ST_W-1:0]   rst_ff;
   logic [TW-1:0]     rtime_ff, rfin_ff, rev_ff;

   // queue row
   cell_ctl_type      ctl;
   job_type           cell_job [QUEUE_DEPTH];
   logic              cell_ge  [QUEUE_DEPTH];
   job_type           head;

   logic              div_start, div_done;
   logic [TW-1:0]     div_q;
   logic [SPEED_W-1:0] div_r;

   logic [TW-1:0]     arr_c, limit, run_eval, new_sim, step_t;
   logic [TW:0]       end_sum;
   logic              queue_full;

   assign head       = cell_job[0];
   assign queue_full = (fill_ff == FILL_W'(QUEUE_DEPTH));

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      edf_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .head_sel (k == 0),
         .valid_i  (FILL_W'(k) < fill_ff),
         .new_job  (new_ff),
         .prev_job ((k == 0) ? new_ff : cell_job[(k == 0) ? 0 : k-1]),
         .prev_ge  ((k == 0) ? 1'b1 : cell_ge[(k == 0) ? 0 : k-1]),
         .next_job ((k == QUEUE_DEPTH-1) ? cell_job[k]
                                          : cell_job[(k == QUEUE_DEPTH-1) ? k : k+1]),
         .job_o    (cell_job[k]),
         .ge_o     (cell_ge[k])
      );
   end

   edf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head.remaining),
      .divisor  (speed_ff),
      .done     (div_done),
      .quo      (div_q),
      .rem      (div_r)
   );

   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      // arrival clamped to now; run window to arrival, horizon or head overrun
      arr_c    = (arr_ff < sim_ff) ? sim_ff : arr_ff;
      limit    = (arr_c < break_ff) ? arr_c : break_ff;
      run_eval = limit - sim_ff;
      if (obreak_ff && (fill_ff != '0) && (head.overrun < arr_c))
         run_eval = (head.overrun > sim_ff) ? head.overrun - sim_ff : '0;
      step_t   = div_q + TW'(div_r != '0);
      new_sim  = part_ff ? sim_ff + run_ff : sim_ff + step_t;
      end_sum  = {1'b0, sim_ff} + {1'b0, run_ff};
   end

   always_comb begin
      state_in   = state_ff;
      sim_in     = sim_ff;
      fill_in    = fill_ff;
      fin_in     = fin_ff;
      ev_in      = ev_ff;
      started_in = started_ff;
      halted_in  = halted_ff;
      arr_in     = arr_ff;
      run_in     = run_ff;
      ovt_in     = ovt_ff;
      ovtv_in    = ovtv_ff;
      st_in      = st_ff;
      ctl.op       = CELL_HOLD;
      ctl.head_rem = head.remaining - prod_ff[TW-1:0];
      div_start  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_EVAL;
               arr_in   = req.arrival_time;
            end
         end
         S_EVAL: begin
            state_in = S_OUT;
            if (halted_ff) begin
               st_in = ST_HALTED;
            end else if (!started_ff) begin
               started_in = 1'b1;
               sim_in     = arr_ff;
               if (queue_full) begin
                  st_in = ST_FULL;
               end else begin
                  st_in   = ST_OK;
                  ctl.op  = CELL_INS;
                  fill_in = fill_ff + 1'b1;
               end
            end else if (sim_ff >= break_ff) begin
               halted_in = 1'b1;
               st_in     = ST_HORIZON;
            end else begin
               arr_in   = arr_c;
               run_in   = run_eval;
               ovtv_in  = (fill_ff != '0);
               ovt_in   = head.overrun;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if ((run_ff != '0) && (fill_ff != '0)) begin
               if (speed_ff == '0) begin
                  state_in = S_MUL;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else begin
               state_in = S_FINAL;
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_MUL;
         end
         S_MUL: state_in = S_APPLY;
         S_APPLY: begin
            ev_in = sat_inc(ev_ff);
            if (part_ff) begin
               ctl.op = CELL_HEAD;
               run_in = '0;
            end else begin
               ctl.op  = CELL_POP;
               run_in  = run_ff - step_t;
               fill_in = fill_ff - 1'b1;
               fin_in  = sat_inc(fin_ff);
            end
            if (new_sim > head.deadline) begin
               sim_in   = head.deadline;
               st_in    = ST_MISS;
               state_in = S_OUT;
            end else begin
               sim_in   = new_sim;
               state_in = S_LOOP;
            end
         end
         S_FINAL: begin
            state_in = S_OUT;
            if ((sim_ff == break_ff) || (end_sum == {1'b0, break_ff})) begin
               sim_in    = break_ff;
               halted_in = 1'b1;
               st_in     = ST_HORIZON;
            end else if (obreak_ff && ovtv_ff && (sim_ff == ovt_ff)) begin
               halted_in = 1'b1;
               st_in     = ST_OVERRUN;
            end else begin
               sim_in = arr_ff;
               if (queue_full) begin
                  st_in = ST_FULL;
               end else begin
                  ctl.op  = CELL_INS;
                  fill_in = fill_ff + 1'b1;
                  ev_in   = sat_inc(ev_ff);
                  st_in   = ST_OK;
               end
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      arr_ff  <= arr_in;
      run_ff  <= run_in;
      ovt_ff  <= ovt_in;
      ovtv_ff <= ovtv_in;
      st_ff   <= st_in;
      prod_ff <= run_ff * speed_ff;
      part_ff <= (speed_ff == '0) || (run_ff <= div_q);
      // arriving job held here until queued
      if (state_ff == S_IDLE && req.valid) begin
         new_ff.deadline  <= req.abs_deadline;
         new_ff.overrun   <= req.overrun_time;
         new_ff.remaining <= req.work_amount;
      end
      if (state_ff == S_OUT && (!rv_ff || rsp.ready)) begin
         rst_ff   <= st_ff;
         rtime_ff <= sim_ff;
         rfin_ff  <= fin_ff;
         rev_ff   <= ev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         speed_ff   <= SPEED_W'(1);
         obreak_ff  <= 1'b0;
         break_ff   <= '1;
         sim_ff     <= '0;
         fill_ff    <= '0;
         fin_ff     <= '0;
         ev_ff      <= '0;
         started_ff <= 1'b0;
         halted_ff  <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sim_ff     <= sim_in;
         fill_ff    <= fill_in;
         fin_ff     <= fin_in;
         ev_ff      <= ev_in;
         started_ff <= started_in;
         halted_ff  <= halted_in;
         if (state_ff == S_OUT && (!rv_ff || rsp.ready)) rv_ff <= 1'b1;
         else if (rsp.ready)                             rv_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_SPEED:  speed_ff  <= csr_wdata[SPEED_W-1:0];
               CSR_OBREAK: obreak_ff <= csr_wdata[0];
               CSR_BREAK:  break_ff  <= csr_wdata[TW-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp.valid          = rv_ff;
   assign rsp.status         = rst_ff;
   assign rsp.time_now       = rtime_ff;
   assign rsp.finished_count = rfin_ff;
   assign rsp.event_count    = rev_ff;
endmodule

// ----- rtl/core/edf_chk.sv -----
module edf_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status
);
   import edf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("rsp dropped while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_HALTED)
      else $error("bad status code");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind edf_schedule_simulator_step edf_chk u_edf_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.status)
);

// ----- tb/tb_top.sv -----
module tb_top;
   import edf_pkg::*;

   // Directed rows are either a register write or one job arrival. A row
   // with chk_st set also carries the status that can be read off by eye.
   typedef enum logic {ROW_CSR, ROW_JOB} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      logic [1:0]    idx;
      logic [31:0]   wdata;
      logic [31:0]   arrival;
      logic [31:0]   overrun;
      logic [31:0]   deadline;
      logic [31:0]   work;
      bit            chk_st;
      logic [ST_W-1:0] st;
   } row_type;

   typedef struct {
      logic [ST_W-1:0] status;
      logic [31:0]     time_now;
      logic [31:0]     finished;
      logic [31:0]     events;
   } sched_result_type;

   typedef struct {
      longint unsigned deadline;
      longint unsigned overrun;
      longint unsigned remaining;
   } pend_job_type;

   localparam int          CYCLE_LIMIT = 3_000_000;
   localparam logic [31:0] T_HI        = 32'hFFFF_FF00;
   localparam logic [31:0] ALL1        = 32'hFFFF_FFFF;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   edf_req_if req ();
   edf_rsp_if rsp ();

   edf_schedule_simulator_step u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ---------------------------------------------------------------------
   // Scheduler predictor: its own copy of registers and job queue.
   // ---------------------------------------------------------------------
   longint unsigned cfg_speed;
   longint unsigned cfg_obreak;
   longint unsigned cfg_horizon;
   longint unsigned sched_now;
   longint unsigned sched_finished;
   longint unsigned sched_events;
   bit              sched_started;
   bit              sched_halted;
   pend_job_type    ready_jobs[$];

   sched_result_type expected_results[$];
   int               fail_count;
   bit               quiet;     // no idling on either side while set

   function automatic longint unsigned sat_up(longint unsigned v);
      return (v < 64'hFFFF_FFFF) ? v + 1 : v;
   endfunction

   // sorted insert, equal deadlines stay first in, first out
   function automatic bit enqueue_job(longint unsigned dl, longint unsigned ovr,
                                      longint unsigned wrk);
      pend_job_type j;
      int           pos;
      if (ready_jobs.size() >= QUEUE_DEPTH)
         return 1'b0;
      pos = 0;
      while (pos < ready_jobs.size() && ready_jobs[pos].deadline <= dl)
         pos++;
      j.deadline  = dl;
      j.overrun   = ovr;
      j.remaining = wrk;
      ready_jobs.insert(pos, j);
      return 1'b1;
   endfunction

   function automatic sched_result_type pack_result(logic [ST_W-1:0] st);
      sched_result_type r;
      r.status   = st;
      r.time_now = sched_now[31:0];
      r.finished = sched_finished[31:0];
      r.events   = sched_events[31:0];
      return r;
   endfunction

   function automatic sched_result_type schedule_arrival(logic [31:0] a, logic [31:0] o,
                                                         logic [31:0] d, logic [31:0] w);
      longint unsigned arr, lim, run, ovt, dl, c, spent;
      bit              ovt_ok;
      arr = a;
      ovt = 0;
      if (sched_halted)
         return pack_result(ST_HALTED);
      if (!sched_started) begin
         // first job only sets the clock and is queued
         sched_started = 1'b1;
         sched_now     = arr;
         return pack_result(enqueue_job(d, o, w) ? ST_OK : ST_FULL);
      end
      if (sched_now >= cfg_horizon) begin
         sched_halted = 1'b1;
         return pack_result(ST_HORIZON);
      end
      if (arr < sched_now)
         arr = sched_now;
      lim = (arr < cfg_horizon) ? arr : cfg_horizon;
      run = lim - sched_now;
      ovt_ok = ready_jobs.size() > 0;
      if (ovt_ok)
         ovt = ready_jobs[0].overrun;
      if (cfg_obreak != 0 && ovt_ok && ovt < arr)
         run = (ovt > sched_now) ? ovt - sched_now : 0;
      // serve the head job until time catches up with the arrival
      while (run > 0 && ready_jobs.size() > 0) begin
         dl = ready_jobs[0].deadline;
         c  = ready_jobs[0].remaining;
         if (cfg_speed == 0 || run <= c / cfg_speed) begin
            sched_now += run;
            ready_jobs[0].remaining = c - run * cfg_speed;
            run = 0;
         end else begin
            spent = c / cfg_speed;
            if (c % cfg_speed > 0) begin
               run       -= 1;
               sched_now += 1;
            end
            sched_now += spent;
            run       -= spent;
            void'(ready_jobs.pop_front());
            sched_finished = sat_up(sched_finished);
         end
         sched_events = sat_up(sched_events);
         if (sched_now > dl) begin
            sched_now = dl;
            return pack_result(ST_MISS);
         end
      end
      if (sched_now == cfg_horizon || sched_now + run == cfg_horizon) begin
         sched_now    = cfg_horizon;
         sched_halted = 1'b1;
         return pack_result(ST_HORIZON);
      end
      if (cfg_obreak != 0 && ovt_ok && sched_now == ovt) begin
         sched_halted = 1'b1;
         return pack_result(ST_OVERRUN);
      end
      sched_now = arr;
      if (!enqueue_job(d, o, w))
         return pack_result(ST_FULL);
      sched_events = sat_up(sched_events);
      return pack_result(ST_OK);
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      sched_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result item", rsp.status, 0);
         end else begin
            e = expected_results.pop_front();
            if (rsp.status !== e.status)
               report_mismatch("status", rsp.status, e.status);
            if (rsp.time_now !== e.time_now)
               report_mismatch("time_now", rsp.time_now, e.time_now);
            if (rsp.finished_count !== e.finished)
               report_mismatch("finished_count", rsp.finished_count, e.finished);
            if (rsp.event_count !== e.events)
               report_mismatch("event_count", rsp.event_count, e.events);
         end
      end
   end

   // receiver stalls at random, about 9 in 100 times, unless quiet is set
   always @(posedge clock) begin
      if (reset)
         rsp.ready <= 1'b0;
      else
         rsp.ready <= quiet || ($urandom_range(0, 99) >= 9);
   end

   int cycles;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------
   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      // only while idle: all results back, then a margin for the last step
      wait (expected_results.size() == 0);
      repeat (12) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SPEED:  cfg_speed   = val[7:0];
         CSR_OBREAK: cfg_obreak  = val[0];
         CSR_BREAK:  cfg_horizon = val;
         default: ;
      endcase
   endtask

   // one arrival item; expected result queued at acceptance
   task automatic send_job(logic [31:0] a, logic [31:0] o, logic [31:0] d, logic [31:0] w,
                           bit chk_st, logic [ST_W-1:0] st);
      sched_result_type r;
      if (!quiet && $urandom_range(0, 99) < 9) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.arrival_time <= a;
      req.overrun_time <= o;
      req.abs_deadline <= d;
      req.work_amount  <= w;
      do @(posedge clock); while (!req.ready);
      r = schedule_arrival(a, o, d, w);
      if (chk_st && r.status !== st)
         report_mismatch("predicted status", r.status, st);
      expected_results.push_back(r);
   endtask

   task automatic run_rows(row_type rows[$]);
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            req.valid <= 1'b0;
            write_csr(rows[i].idx, rows[i].wdata);
         end else begin
            send_job(rows[i].arrival, rows[i].overrun, rows[i].deadline, rows[i].work,
                     rows[i].chk_st, rows[i].st);
         end
      end
      req.valid <= 1'b0;
   endtask

   function automatic row_type csr_row(logic [1:0] idx, logic [31:0] val);
      row_type r;
      r = '{kind: ROW_CSR, idx: idx, wdata: val, arrival: 0, overrun: 0, deadline: 0,
            work: 0, chk_st: 1'b0, st: ST_OK};
      return r;
   endfunction

   function automatic row_type job_row(logic [31:0] a, logic [31:0] o, logic [31:0] d,
                                       logic [31:0] w, bit chk, logic [ST_W-1:0] st);
      row_type r;
      r = '{kind: ROW_JOB, idx: 0, wdata: 0, arrival: a, overrun: o, deadline: d,
            work: w, chk_st: chk, st: st};
      return r;
   endfunction

   initial begin
      row_type         opening[$];
      row_type         closing[$];
      logic [31:0]     t_nom, a, o, d, w, spd;
      int              per_phase;

      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_SPEED;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.arrival_time = '0;
      req.overrun_time = '0;
      req.abs_deadline = '0;
      req.work_amount  = '0;
      quiet        = 1'b0;
      fail_count   = 0;
      cycles       = 0;
      cfg_speed    = 1;
      cfg_obreak   = 0;
      cfg_horizon  = 64'hFFFF_FFFF;
      sched_now    = 0;
      sched_finished = 0;
      sched_events = 0;
      sched_started = 1'b0;
      sched_halted  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Opening: first job, preemption, late arrival, zero work, huge work,
      // an overrun time already past with the break on, speed extremes.
      // Huge jobs carry the latest deadline so they only soak up idle time.
      opening.push_back(job_row(100, ALL1, 1000, 10, 1'b1, ST_OK));
      opening.push_back(job_row(105, 0, 400, 0, 1'b0, ST_OK));
      opening.push_back(job_row(50, 32'h7FFF_FFFF, 1200, 3, 1'b0, ST_OK));
      opening.push_back(csr_row(CSR_OBREAK, 1));
      opening.push_back(job_row(300, 32'h1234_5678, ALL1, ALL1, 1'b0, ST_OK));
      opening.push_back(csr_row(CSR_OBREAK, 0));
      opening.push_back(csr_row(CSR_SPEED, 255));
      opening.push_back(job_row(400, 0, 2000, 1000, 1'b0, ST_OK));
      opening.push_back(csr_row(CSR_SPEED, 0));
      opening.push_back(job_row(410, 32'hAAAA_5555, ALL1, 32'h5555_AAAA, 1'b0, ST_OK));
      opening.push_back(csr_row(CSR_BREAK, ALL1));
      run_rows(opening);

      // Random phases: offered load about half the capacity so that the
      // queue keeps moving and deadlines are met; a few late arrivals.
      t_nom = 500;
      per_phase = 300;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: spd = 1;
            1: spd = 255;
            2: spd = $urandom_range(2, 254);
            3: spd = $urandom_range(1, 16);
            default: spd = $urandom_range(1, 255);
         endcase
         req.valid <= 1'b0;
         write_csr(CSR_SPEED, spd);
         write_csr(CSR_OBREAK, (ph == 3) ? 1 : 0);
         quiet = (ph == 1);
         for (int n = 0; n < per_phase; n++) begin
            if ($urandom_range(0, 9) != 0)
               t_nom += $urandom_range(0, 40);
            a = ($urandom_range(0, 19) == 0) ? $urandom_range(0, t_nom) : t_nom;
            w = $urandom_range(0, spd * 20);
            d = t_nom + $urandom_range(400, 4000);
            // with the break on, overrun times stay far beyond any arrival
            o = (ph == 3) ? {1'b1, 31'($urandom)} : $urandom;
            send_job(a, o, d, w, 1'b0, ST_OK);
         end
         quiet = 1'b0;
      end
      req.valid <= 1'b0;

      // Closing: drain the queue at full speed up near the top of the time
      // range, fill the queue at speed zero, overflow it, miss a deadline,
      // then stop on an overrun and see the block stay halted.
      closing.push_back(csr_row(CSR_SPEED, 255));
      closing.push_back(job_row(T_HI, T_HI + 5, T_HI + 5, 0, 1'b0, ST_OK));
      closing.push_back(csr_row(CSR_SPEED, 0));
      closing.push_back(csr_row(CSR_BREAK, 32'hFFFF_FFF8));
      closing.push_back(job_row(T_HI, T_HI + 5, T_HI + 5, 5, 1'b0, ST_OK));
      for (int k = 0; k < 14; k++)
         closing.push_back(job_row(T_HI, ALL1, 32'hFFFF_FFF0, 5, 1'b0, ST_OK));
      closing.push_back(job_row(T_HI, ALL1, 32'hFFFF_FFF0, 5, 1'b1, ST_FULL));
      closing.push_back(job_row(T_HI + 10, ALL1, ALL1, 1, 1'b1, ST_MISS));
      closing.push_back(csr_row(CSR_OBREAK, 1));
      closing.push_back(job_row(T_HI + 20, ALL1, ALL1, 1, 1'b1, ST_OVERRUN));
      closing.push_back(job_row(T_HI + 30, 0, 0, 0, 1'b1, ST_HALTED));
      closing.push_back(job_row(ALL1, ALL1, ALL1, ALL1, 1'b1, ST_HALTED));
      run_rows(closing);

      wait (expected_results.size() == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
